/* rtl/core/whc_pkg.sv */
`default_nettype none

package whc_pkg;

  // Iteration count of the vectoring unit
  localparam int CORDIC_ITERATIONS_DEF = 16;

  // Angle table index width (table covers 32 iterations)
  localparam int ATAN_IDX_W = 5;

  // Fixed-point constants
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] Z_ROUND     = 35'sd65536;
  localparam logic signed [34:0] BEARING_MAX = 35'sd25736;
  localparam logic [19:0]        INV_GAIN    = 20'd636751;
  localparam logic [62:0]        DIST_ROUND  = 63'd134217728;

  // Command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  // Phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TURNING   = 3'd1;
  localparam logic [2:0] PH_DRIVING   = 3'd2;
  localparam logic [2:0] PH_ARRIVED   = 3'd3;
  localparam logic [2:0] PH_CANCELLED = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_DIST_TOL  = 3'd2;
  localparam logic [2:0] REG_YAW_TOL   = 3'd3;
  localparam logic [2:0] REG_TURN_SPD  = 3'd4;
  localparam logic [2:0] REG_FWD_SPD   = 3'd5;

  // Register reset values
  localparam logic [30:0] DIST_TOL_RST = 31'd3277;
  localparam logic [14:0] YAW_TOL_RST  = 15'd286;
  localparam logic [15:0] TURN_SPD_RST = 16'd42598;
  localparam logic [15:0] FWD_SPD_RST  = 16'd39322;

  // Result of the vectoring unit
  typedef struct packed {
    logic               valid;
    logic signed [15:0] bearing;
    logic [32:0]        mag;
  } whc_vec_t;

  // Arctangent of 2^-i in radians, Q.30, rounded to nearest
  function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/whc_cordic.sv */
`default_nettype none

module whc_cordic #(
  parameter int CORDIC_ITERATIONS = whc_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] goal_x,
  input  wire logic signed [31:0] goal_y,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  output whc_pkg::whc_vec_t       res
);

  localparam int CNT_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_ITERATIONS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_MUL0 = 3'd4;
  localparam logic [2:0] S_MUL1 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic               zero_vec;
  logic signed [43:0] x;
  logic signed [43:0] y;
  logic signed [34:0] z;
  logic [62:0]        acc;
  logic signed [15:0] bearing;
  logic [32:0]        mag;

  logic signed [43:0] dx_w;
  logic signed [43:0] dy_w;
  logic signed [43:0] xs;
  logic signed [43:0] ys;
  logic signed [34:0] ang;
  logic [20:0]        mul_a;
  logic [40:0]        prod;
  logic signed [34:0] z_rnd;
  logic signed [34:0] zq;
  logic [62:0]        d_rnd;
  logic [34:0]        d_q;

  // Scale differences by 2^8 into the working width
  assign dx_w = {{11{dx[32]}}, dx} <<< 8;
  assign dy_w = {{11{dy[32]}}, dy} <<< 8;

  // Shared rotation step: shift by the iteration index, add or subtract the table angle
  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign ang = $signed({5'b0, whc_pkg::atan_q30(whc_pkg::ATAN_IDX_W'(cnt))});

  // Shared gain multiplier, one half of the magnitude per cycle
  assign mul_a = (state == S_MUL0) ? x[20:0] : x[41:21];
  assign prod  = mul_a * whc_pkg::INV_GAIN;

  // Round bearing and magnitude
  assign z_rnd = z + whc_pkg::Z_ROUND;
  assign zq    = z_rnd >>> 17;
  assign d_rnd = acc + whc_pkg::DIST_ROUND;
  assign d_q   = d_rnd[62:28];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) state <= S_LOAD;
        end
        S_LOAD: state <= S_PRE;
        S_PRE: begin
          state <= S_ITER;
          cnt   <= '0;
        end
        S_ITER: begin
          if (cnt == CNT_LAST) begin
            state <= S_MUL0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_FIN;
        S_FIN:  state <= S_DONE;
        S_DONE: begin
          if (start) state <= S_LOAD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        dx <= {goal_x[31], goal_x} - {pos_x[31], pos_x};
        dy <= {goal_y[31], goal_y} - {pos_y[31], pos_y};
      end
      S_PRE: begin
        zero_vec <= (dx == '0) && (dy == '0);
        // Fold the left half plane onto the right by a half turn
        if (dx[32]) begin
          x <= -dx_w;
          y <= -dy_w;
          z <= dy[32] ? -whc_pkg::PI_Q30 : whc_pkg::PI_Q30;
        end else begin
          x <= dx_w;
          y <= dy_w;
          z <= '0;
        end
      end
      S_ITER: begin
        if (!y[43]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end
      end
      S_MUL0: acc <= {22'b0, prod};
      S_MUL1: acc <= acc + {1'b0, prod, 21'b0};
      S_FIN: begin
        if (zero_vec) begin
          bearing <= '0;
          mag     <= '0;
        end else begin
          if (zq > whc_pkg::BEARING_MAX) begin
            bearing <= 16'(whc_pkg::BEARING_MAX);
          end else if (zq < -whc_pkg::BEARING_MAX) begin
            bearing <= 16'(-whc_pkg::BEARING_MAX);
          end else begin
            bearing <= 16'(zq);
          end
          mag <= (d_q[34:33] != 2'b00) ? '1 : d_q[32:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid   = (state == S_DONE);
  assign res.bearing = bearing;
  assign res.mag     = mag;

endmodule

`default_nettype wire

/* rtl/core/waypoint_heading_controller.sv */
// Go-to-point heading controller.
// Input stream: s_tuser carries the command (tick, start goal, cancel), s_tdata
// the pose sample. One result beat comes out per input beat on the m_ side;
// m_tlast marks the beat that ends a goal (arrived or cancelled).
// Goal, tolerances and speeds are written on the cfg port (index, data),
// always ready; write only while no item is in flight.
// An item is taken only when the previous one has left the vectoring unit,
// so no new beat is accepted while one is still in the vectoring unit. The
// iterative CORDIC (one shift-add step per cycle, then the gain multiply in
// two halves) sets this pace.
// The result sits in an output register: while the receiver stalls, the
// next input beat is still accepted and processed, and it waits in the
// vectoring unit until the output register frees up.
// Reset (synchronous, rst high) clears the running flag, empties the output
// register and loads the default goal (origin), tolerances and speeds.
`default_nettype none

module waypoint_heading_controller #(
  parameter int CORDIC_ITERATIONS = whc_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,   // linear_speed[15:0], angular_speed[32:16],
                                      // phase[35:33], position_ok[36],
                                      // heading_ok[37], distance_error[70:38],
                                      // heading_error[87:71]
  output logic             m_tlast,   // done_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic T_IDLE = 1'b0;
  localparam logic T_BUSY = 1'b1;

  logic               state;
  logic               running;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;

  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic [30:0]        dist_tolerance;
  logic [14:0]        yaw_tolerance;
  logic [15:0]        turn_speed;
  logic [15:0]        forward_speed;

  whc_pkg::whc_vec_t  vec;
  logic               start;
  logic               load;
  logic               running_next;

  logic signed [16:0] herr;
  logic [16:0]        habs;
  logic [18:0]        yaw_tol10;
  logic               run_now;
  logic [15:0]        lin;
  logic signed [16:0] angv;
  logic [2:0]         phase;
  logic               done;
  logic               pok;
  logic               hok;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == T_IDLE);
  assign start     = s_tvalid && s_tready;
  assign load      = (state == T_BUSY) && vec.valid && (!m_tvalid || m_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x         <= '0;
      goal_y         <= '0;
      dist_tolerance <= whc_pkg::DIST_TOL_RST;
      yaw_tolerance  <= whc_pkg::YAW_TOL_RST;
      turn_speed     <= whc_pkg::TURN_SPD_RST;
      forward_speed  <= whc_pkg::FWD_SPD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        whc_pkg::REG_GOAL_X:   goal_x         <= cfg_data;
        whc_pkg::REG_GOAL_Y:   goal_y         <= cfg_data;
        whc_pkg::REG_DIST_TOL: dist_tolerance <= cfg_data[30:0];
        whc_pkg::REG_YAW_TOL:  yaw_tolerance  <= cfg_data[14:0];
        whc_pkg::REG_TURN_SPD: turn_speed     <= cfg_data[15:0];
        whc_pkg::REG_FWD_SPD:  forward_speed  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (start) begin
      cmd     <= s_tuser;
      pos_x   <= s_tdata[31:0];
      pos_y   <= s_tdata[63:32];
      heading <= s_tdata[79:64];
    end
  end

  whc_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .goal_x (goal_x),
    .goal_y (goal_y),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .res    (vec)
  );

  // Heading error and goal decision on the same sample
  assign herr      = {vec.bearing[15], vec.bearing} - {heading[15], heading};
  assign habs      = herr[16] ? 17'(-herr) : 17'(herr);
  assign yaw_tol10 = {1'b0, yaw_tolerance, 3'b0} + {3'b0, yaw_tolerance, 1'b0};
  assign run_now   = running || (cmd == whc_pkg::CMD_START);

  always_comb begin
    lin          = '0;
    angv         = '0;
    phase        = whc_pkg::PH_IDLE;
    done         = 1'b0;
    pok          = 1'b0;
    hok          = 1'b0;
    running_next = run_now;
    if (run_now) begin
      if (cmd == whc_pkg::CMD_CANCEL) begin
        running_next = 1'b0;
        phase        = whc_pkg::PH_CANCELLED;
        done         = 1'b1;
      end else if (vec.mag <= {2'b0, dist_tolerance}) begin
        running_next = 1'b0;
        phase        = whc_pkg::PH_ARRIVED;
        done         = 1'b1;
        pok          = 1'b1;
        hok          = ({2'b0, habs} <= yaw_tol10);
      end else if (habs > {2'b0, yaw_tolerance}) begin
        phase = whc_pkg::PH_TURNING;
        angv  = (herr > 17'sd0) ? $signed({1'b0, turn_speed})
                                : -$signed({1'b0, turn_speed});
      end else begin
        phase = whc_pkg::PH_DRIVING;
        lin   = forward_speed;
      end
    end
  end

  // Sequencer and running flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      running <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) state <= T_BUSY;
        end
        T_BUSY: begin
          if (load) begin
            state   <= T_IDLE;
            running <= running_next;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Output register: hold while stalled, drop after the beat is taken unless a new result loads
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {herr, vec.mag, hok, pok, phase, angv, lin};
      m_tlast <= done;
    end
  end

endmodule

`default_nettype wire
